>>> hw/rtl/assert_macros.svh
// Assertion macros for the position solver checkers.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on clk, disabled in reset.
`define TLPS_AST_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tlps: check failed");

// Next-cycle implication, clocked on clk, disabled in reset.
`define TLPS_AST_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tlps: check failed");

`endif

>>> hw/rtl/tlps_pkg.sv
package tlps_pkg;

  localparam int DIST_BITS_DEF    = 20;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int FRAC_BITS        = 6;
  localparam int CFG_W            = 16;
  localparam int CFG_IDX_W        = 3;
  localparam int OUT_W            = 22;
  localparam int GAIN_W           = 24;
  localparam int GAIN_FRAC        = 24;
  localparam int ATAN_W           = 31;
  localparam int Z_W              = ATAN_W + 3;
  localparam int LAT_W            = 17;
  localparam int SB_W             = LAT_W + CFG_W + 2;

  localparam logic [GAIN_W-1:0] GAIN_Q24 = 24'd10188014;

  localparam logic [CFG_IDX_W-1:0] REG_FRONT_DOFF = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_DOFF = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_YAW_OFF    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FRONT_LAT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_LAT  = 3'd4;

  typedef struct packed {
    logic signed [OUT_W-1:0] mm;
    logic                    ok;
  } lane_res_t;

  // magnitude bits of a corrected range
  function automatic int dmag_bits(int db);
    return ((db > 15) ? db : 15) + 1;
  endfunction

  function automatic int lane_lat(int db, int steps);
    return 6 + dmag_bits(db) + steps;
  endfunction

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic [ATAN_W-1:0] atan_val(int i);
    logic [ATAN_W-1:0] v;
    case (i)
      0:  v = 31'd536870912;
      1:  v = 31'd316933406;
      2:  v = 31'd167458907;
      3:  v = 31'd85004756;
      4:  v = 31'd42667331;
      5:  v = 31'd21354465;
      6:  v = 31'd10680862;
      7:  v = 31'd5340245;
      8:  v = 31'd2670163;
      9:  v = 31'd1335087;
      10: v = 31'd667544;
      11: v = 31'd333772;
      12: v = 31'd166886;
      13: v = 31'd83443;
      14: v = 31'd41722;
      15: v = 31'd20861;
      16: v = 31'd10430;
      17: v = 31'd5215;
      18: v = 31'd2608;
      19: v = 31'd1304;
      20: v = 31'd652;
      21: v = 31'd326;
      22: v = 31'd163;
      23: v = 31'd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

>>> hw/rtl/tlps_root.sv
module tlps_root import tlps_pkg::*; #(
  parameter int DMW = 21
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [2*DMW-1:0]     rad,
  input  logic [SB_W-1:0]      side_in,
  output logic [DMW-1:0]       root,
  output logic [SB_W-1:0]      side_out
);

  localparam int RW = 2 * DMW + 1;

  logic [RW-1:0]   rem_r [DMW];
  logic [DMW-1:0]  q_r   [DMW];
  logic [SB_W-1:0] sb_r  [DMW];

  // one root bit per stage, MSB first
  for (genvar j = 0; j < DMW; j++) begin : g_stage
    localparam int B = DMW - 1 - j;
    logic [RW-1:0]   rem_in, trial, rem_nxt;
    logic [DMW-1:0]  q_in, q_nxt;
    logic [SB_W-1:0] sb_in;

    if (j == 0) begin : g_first
      assign rem_in = {1'b0, rad};
      assign q_in   = '0;
      assign sb_in  = side_in;
    end else begin : g_next
      assign rem_in = rem_r[j-1];
      assign q_in   = q_r[j-1];
      assign sb_in  = sb_r[j-1];
    end

    assign trial = ({{(RW-DMW){1'b0}}, q_in} << (B + 1)) | (RW'(1) << (2 * B));

    always_comb begin
      rem_nxt = rem_in;
      q_nxt   = q_in;
      if (rem_in >= trial) begin
        rem_nxt = rem_in - trial;
        q_nxt   = q_in | (DMW'(1) << B);
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j] <= rem_nxt;
        q_r[j]   <= q_nxt;
        sb_r[j]  <= sb_in;
      end
    end
  end

  assign root     = q_r[DMW-1];
  assign side_out = sb_r[DMW-1];

endmodule

>>> hw/rtl/tlps_cordic.sv
module tlps_cordic import tlps_pkg::*; #(
  parameter int CW    = 30,
  parameter int STEPS = CORDIC_STEPS_DEF
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [CW-1:0] x0,
  input  logic signed [CW-1:0] y0,
  input  logic signed [Z_W-1:0] z0,
  input  logic                 ok_in,
  output lane_res_t            res
);

  localparam int MLO = 21;
  localparam int PW  = CW + GAIN_W + 1;
  localparam int RSH = GAIN_FRAC + FRAC_BITS;

  logic signed [CW-1:0]  x_r [STEPS];
  logic signed [CW-1:0]  y_r [STEPS];
  logic signed [Z_W-1:0] z_r [STEPS];
  logic                  ok_r [STEPS];

  for (genvar i = 0; i < STEPS; i++) begin : g_rot
    logic signed [CW-1:0]  x_in, y_in, xs, ys, x_nxt, y_nxt;
    logic signed [Z_W-1:0] z_in, z_nxt, at;
    logic                  ok_i;

    if (i == 0) begin : g_first
      assign x_in = x0;
      assign y_in = y0;
      assign z_in = z0;
      assign ok_i = ok_in;
    end else begin : g_next
      assign x_in = x_r[i-1];
      assign y_in = y_r[i-1];
      assign z_in = z_r[i-1];
      assign ok_i = ok_r[i-1];
    end

    assign xs = x_in >>> i;
    assign ys = y_in >>> i;
    assign at = $signed({3'b000, atan_val(i)});

    always_comb begin
      if (z_in >= 0) begin
        x_nxt = x_in - ys;
        y_nxt = y_in + xs;
        z_nxt = z_in - at;
      end else begin
        x_nxt = x_in + ys;
        y_nxt = y_in - xs;
        z_nxt = z_in + at;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[i]  <= x_nxt;
        y_r[i]  <= y_nxt;
        z_r[i]  <= z_nxt;
        ok_r[i] <= ok_i;
      end
    end
  end

  // gain correction: -y * 1/K from |y|, rounded half away from zero and saturated; zero when not ok
  logic signed [CW-1:0]      y_fin;
  logic [CW-1:0]             m_r, m_nxt;
  logic                      neg_r, ok1_r, neg2_r, ok2_r;
  logic [MLO+GAIN_W-1:0]     plo_r;
  logic [CW-MLO+GAIN_W-1:0]  phi_r;
  logic [PW-1:0]             sum, rs;
  logic signed [OUT_W-1:0]   val;
  lane_res_t                 res_r, res_nxt;

  assign y_fin = y_r[STEPS-1];
  assign m_nxt = y_fin[CW-1] ? CW'(-y_fin) : y_fin;

  assign sum = (PW'(phi_r) << MLO) + PW'(plo_r) + (PW'(1) << (RSH - 1));
  assign rs  = sum >> RSH;

  always_comb begin
    if (neg2_r) begin
      if (rs > PW'(2**(OUT_W-1) - 1)) val = {1'b0, {(OUT_W-1){1'b1}}};
      else                            val = rs[OUT_W-1:0];
    end else begin
      if (rs > PW'(2**(OUT_W-1)))     val = {1'b1, {(OUT_W-1){1'b0}}};
      else                            val = -rs[OUT_W-1:0];
    end
    res_nxt.ok = ok2_r;
    res_nxt.mm = ok2_r ? val : '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_r    <= m_nxt;
      neg_r  <= y_fin[CW-1];
      ok1_r  <= ok_r[STEPS-1];
      plo_r  <= m_r[MLO-1:0] * GAIN_Q24;
      phi_r  <= m_r[CW-1:MLO] * GAIN_Q24;
      neg2_r <= neg_r;
      ok2_r  <= ok1_r;
      res_r  <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

>>> hw/rtl/tlps_lane.sv
module tlps_lane import tlps_pkg::*; #(
  parameter int DIST_BITS    = DIST_BITS_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic [DIST_BITS-1:0]    dist_raw,
  input  logic signed [CFG_W-1:0] doff,
  input  logic signed [LAT_W-1:0] y0,
  input  logic signed [CFG_W-1:0] yaw,
  output lane_res_t               res
);

  localparam int DMW = dmag_bits(DIST_BITS);
  localparam int H   = (DMW + 1) / 2;
  localparam int L2  = DMW - H;
  localparam int CW  = DMW + FRAC_BITS + 3;

  // front end: offset, solvability, quadrant fold
  logic signed [DMW:0]       d_s;
  logic signed [LAT_W-1:0]   ak_s;
  logic [CFG_W-1:0]          ak;
  logic                      ok_nxt, flip;
  logic [CFG_W-1:0]          z_nxt;

  assign d_s    = $signed({{(DMW+1-DIST_BITS){1'b0}}, dist_raw})
                + $signed({{(DMW+1-CFG_W){doff[CFG_W-1]}}, doff});
  assign ak_s   = y0[LAT_W-1] ? -y0 : y0;
  assign ak     = ak_s[CFG_W-1:0];
  assign ok_nxt = !d_s[DMW] && (d_s != '0) && (DMW'(ak) <= d_s[DMW-1:0]);
  assign flip   = (yaw > 16384) || (yaw < -16384);
  assign z_nxt  = flip ? {~yaw[CFG_W-1], yaw[CFG_W-2:0]} : yaw;

  logic [DMW-1:0]   dm_r;
  logic [CFG_W-1:0] ak_r;
  logic [SB_W-1:0]  sb0_r, sb1_r, sb2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      dm_r  <= d_s[DMW-1:0];
      ak_r  <= ak;
      sb0_r <= {y0, z_nxt, flip, ok_nxt};
    end
  end

  // squares of range and lateral offset, then their difference
  logic [2*L2-1:0]  hh_r;
  logic [L2+H-1:0]  hl_r;
  logic [2*H-1:0]   ll_r;
  logic [2*CFG_W-1:0] k2_r;
  logic [2*DMW-1:0] n_r;

  always_ff @(posedge clk) begin
    if (en) begin
      hh_r  <= dm_r[DMW-1:H] * dm_r[DMW-1:H];
      hl_r  <= dm_r[DMW-1:H] * dm_r[H-1:0];
      ll_r  <= dm_r[H-1:0] * dm_r[H-1:0];
      k2_r  <= ak_r * ak_r;
      sb1_r <= sb0_r;
      n_r   <= ((2*DMW)'(hh_r) << (2 * H)) + ((2*DMW)'(hl_r) << (H + 1))
             + (2*DMW)'(ll_r) - (2*DMW)'(k2_r);
      sb2_r <= sb1_r;
    end
  end

  logic [DMW-1:0]  c;
  logic [SB_W-1:0] sb3;

  tlps_root #(.DMW(DMW)) u_root (
    .clk      (clk),
    .en       (en),
    .rad      (n_r),
    .side_in  (sb2_r),
    .root     (c),
    .side_out (sb3)
  );

  logic signed [LAT_W-1:0] y0_d;
  logic signed [CFG_W-1:0] z_d;
  logic                    flip_d, ok_d;
  logic signed [CW-1:0]    xc, yc, x0, y0c;
  logic signed [Z_W-1:0]   z0;

  assign {y0_d, z_d, flip_d, ok_d} = sb3;
  assign xc  = $signed(CW'(c) << FRAC_BITS);
  assign yc  = $signed({{(CW-LAT_W){y0_d[LAT_W-1]}}, y0_d} << FRAC_BITS);
  assign x0  = flip_d ? -xc : xc;
  assign y0c = flip_d ? -yc : yc;
  assign z0  = $signed({{(Z_W-CFG_W-16){z_d[CFG_W-1]}}, z_d, 16'h0000});

  tlps_cordic #(.CW(CW), .STEPS(CORDIC_STEPS)) u_cordic (
    .clk   (clk),
    .en    (en),
    .x0    (x0),
    .y0    (y0c),
    .z0    (z0),
    .ok_in (ok_d),
    .res   (res)
  );

endmodule

>>> hw/rtl/two_laser_position_solver_top.sv
// channel  direction  handshake             payload
// in       input      in_valid / in_stall   front_distance, right_distance, yaw_angle
// out      output     out_valid / out_stall x_mm, y_mm, x_valid, y_valid
// cfg      input      cfg_we                cfg_index, cfg_wdata
//
// One item per cycle when the output is not stalled. The square root pipeline depth is
// max(DIST_BITS,15)+1.
// Two lanes (front, right) run square root, CORDIC and gain stages side by side.
// A stalled output register freezes the whole pipeline and stalls the input.
// Synchronous reset clears the configuration registers and all valid bits.
module two_laser_position_solver_top import tlps_pkg::*; #(
  parameter int DIST_BITS    = DIST_BITS_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [DIST_BITS-1:0]    in_front_distance,
  input  logic [DIST_BITS-1:0]    in_right_distance,
  input  logic signed [CFG_W-1:0] in_yaw_angle,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [OUT_W-1:0] out_x_mm,
  output logic signed [OUT_W-1:0] out_y_mm,
  output logic                    out_x_valid,
  output logic                    out_y_valid,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_W-1:0]        cfg_wdata
);

  localparam int LAT = lane_lat(DIST_BITS, CORDIC_STEPS);

  logic [CFG_W-1:0] front_doff_r, right_doff_r, yaw_off_r, front_lat_r, right_lat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_doff_r <= '0;
      right_doff_r <= '0;
      yaw_off_r    <= '0;
      front_lat_r  <= '0;
      right_lat_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRONT_DOFF: front_doff_r <= cfg_wdata;
        REG_RIGHT_DOFF: right_doff_r <= cfg_wdata;
        REG_YAW_OFF:    yaw_off_r    <= cfg_wdata;
        REG_FRONT_LAT:  front_lat_r  <= cfg_wdata;
        REG_RIGHT_LAT:  right_lat_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic adv;
  logic out_valid_r;

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  logic signed [CFG_W-1:0] yaw;
  logic signed [LAT_W-1:0] y0_front, y0_right;

  assign yaw      = in_yaw_angle + yaw_off_r;
  assign y0_front = -$signed({front_lat_r[CFG_W-1], front_lat_r});
  assign y0_right = $signed({right_lat_r[CFG_W-1], right_lat_r});

  lane_res_t res_f, res_r;

  tlps_lane #(.DIST_BITS(DIST_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_front (
    .clk      (clk),
    .en       (adv),
    .dist_raw (in_front_distance),
    .doff     (front_doff_r),
    .y0       (y0_front),
    .yaw      (yaw),
    .res      (res_f)
  );

  tlps_lane #(.DIST_BITS(DIST_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_right (
    .clk      (clk),
    .en       (adv),
    .dist_raw (in_right_distance),
    .doff     (right_doff_r),
    .y0       (y0_right),
    .yaw      (yaw),
    .res      (res_r)
  );

  logic [LAT-1:0] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= {vld_r[LAT-2:0], in_valid};
      out_valid_r <= vld_r[LAT-1];
    end
  end

  // merge lanes into the output register
  logic signed [OUT_W-1:0] x_mm_r, y_mm_r;
  logic                    x_ok_r, y_ok_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      x_mm_r <= res_r.mm;
      x_ok_r <= res_r.ok;
      y_mm_r <= res_f.mm;
      y_ok_r <= res_f.ok;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_x_mm    = x_mm_r;
  assign out_y_mm    = y_mm_r;
  assign out_x_valid = x_ok_r;
  assign out_y_valid = y_ok_r;

endmodule

>>> hw/rtl/tlps_checker.sv
`include "assert_macros.svh"

module tlps_checker import tlps_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_stall,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic signed [OUT_W-1:0] out_x_mm,
  input logic signed [OUT_W-1:0] out_y_mm,
  input logic                    out_x_valid,
  input logic                    out_y_valid
);

  `TLPS_AST_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_x_mm) && $stable(out_y_mm) && $stable(out_x_valid) && $stable(out_y_valid))
  `TLPS_AST_NOW(a_stall_src, in_stall, out_valid && out_stall)
  `TLPS_AST_NOW(a_x_zero, out_valid && !out_x_valid, out_x_mm == '0)
  `TLPS_AST_NOW(a_y_zero, out_valid && !out_y_valid, out_y_mm == '0)

endmodule

bind two_laser_position_solver_top tlps_checker u_tlps_checker (.*);
